@@ sv/swtq_pkg.sv @@
// Package: shared types and constants of the sliding window track quality block.
`timescale 1ns / 1ps

package swtq_pkg;

    localparam int FRAME_W  = 20;
    localparam int PID_W    = 10;
    localparam int STATUS_W = 2;
    localparam int WIDTH_W  = 12;
    localparam int COUNT_W  = 11;
    localparam int FRAC_W   = 17;
    localparam int MAXW_W   = 7;

    localparam logic [MAXW_W-1:0] RESULT_CAP = 7'd64;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BROKEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CAP    = 2'd3;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_FRACTION = 2'd0;
    localparam logic [1:0] REG_BASE     = 2'd1;
    localparam logic [1:0] REG_STEP     = 2'd2;
    localparam logic [1:0] REG_MAXWIN   = 2'd3;

    localparam logic [FRAC_W-1:0]  FRACTION_RST = 17'd58982;
    localparam logic [WIDTH_W-1:0] BASE_RST     = 12'd1000;
    localparam logic [WIDTH_W-1:0] STEP_RST     = 12'd10;
    localparam logic [MAXW_W-1:0]  MAXWIN_RST   = 7'd64;

    typedef struct packed {
        logic [FRAC_W-1:0]  fraction;
        logic [WIDTH_W-1:0] base_window;
        logic [WIDTH_W-1:0] window_step;
        logic [MAXW_W-1:0]  max_windows;
    } cfg_t;

    // Summary of one loaded run, handed from the front to the back
    typedef struct packed {
        logic               over_capacity;
        logic [FRAME_W-1:0] earliest;
        logic [FRAME_W-1:0] latest;
        logic [PID_W-1:0]   largest;
    } run_desc_t;

endpackage

@@ sv/swtq_if.sv @@
// Interfaces: record input channel and result output channel.
`timescale 1ns / 1ps

interface swtq_rec_if;
    logic                         valid;
    logic                         ready;
    logic [swtq_pkg::FRAME_W-1:0] frame_number;
    logic [swtq_pkg::PID_W-1:0]   particle_id;
    logic                         final_record;

    modport source (output valid, frame_number, particle_id, final_record, input ready);
    modport sink   (input valid, frame_number, particle_id, final_record, output ready);
endinterface

interface swtq_res_if;
    logic                          valid;
    logic                          ready;
    logic [swtq_pkg::STATUS_W-1:0] status;
    logic [swtq_pkg::WIDTH_W-1:0]  window_width;
    logic [swtq_pkg::COUNT_W-1:0]  best_good_count;
    logic [swtq_pkg::FRAME_W-1:0]  best_start_frame;
    logic                          last_result;

    modport source (output valid, status, window_width, best_good_count, best_start_frame,
                    last_result, input ready);
    modport sink   (input valid, status, window_width, best_good_count, best_start_frame,
                    last_result, output ready);
endinterface

@@ sv/sliding_window_track_quality.sv @@
// Top level: sliding window track quality counter with APB register port.
//
//  channel   | direction | handshake     | carries
//  ----------+-----------+---------------+------------------------------------------
//  rec_in    | in        | valid/ready   | frame_number, particle_id, final_record
//  res_out   | out       | valid/ready   | status, window_width, best_good_count,
//            |           |               | best_start_frame, last_result
//  apb       | in        | psel/penable  | four configuration registers at 4*i
//
// Records are taken one per cycle while a run loads and the queue has room;
// each request within the record and particle limits is written into the
// record memories at the running count. The final record hands a run summary
// through a two-entry queue to the sweep engine and closes the input until
// every result of that run has been issued. The sweep is a sequencer over
// one-read, one-write memories, with one memory access per step of the
// grouping and sliding loops.
// Reset clears all control state; the stores need no clearing pass because
// every entry is written in a run before it is read. A stalled result holds in
// the output register and freezes the sequencer, not the input.

`timescale 1ns / 1ps

module sliding_window_track_quality #(
    parameter int MAX_RECORDS   = 65536,
    parameter int MAX_FRAMES    = 4096,
    parameter int MAX_PARTICLES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    swtq_rec_if.sink    rec_in,
    swtq_res_if.source  res_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import swtq_pkg::*;

    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int AW = $clog2(MAX_RECORDS);
    localparam int QW = $bits(run_desc_t) + CW;

    // Configuration registers
    logic [FRAC_W-1:0]  fraction_reg;
    logic [WIDTH_W-1:0] base_reg;
    logic [WIDTH_W-1:0] step_reg;
    logic [MAXW_W-1:0]  maxwin_reg;
    logic               cfg_write;
    cfg_t               cfg;

    // Front to memories and queue
    logic               rec_we;
    logic [AW-1:0]      rec_waddr;
    logic [FRAME_W-1:0] rec_wframe;
    logic [PID_W-1:0]   rec_wpid;
    logic [AW-1:0]      rec_raddr;
    logic [FRAME_W-1:0] rec_rframe;
    logic [PID_W-1:0]   rec_rpid;
    logic               push;
    run_desc_t          push_desc;
    logic [CW-1:0]      push_count;
    logic               q_not_full;
    logic               q_not_empty;
    logic               q_pop;
    logic [QW-1:0]      q_data;
    run_desc_t          pop_desc;
    logic [CW-1:0]      pop_count;
    logic               sweep_done;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fraction_reg <= FRACTION_RST;
            base_reg     <= BASE_RST;
            step_reg     <= STEP_RST;
            maxwin_reg   <= MAXWIN_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_FRACTION: fraction_reg <= pwdata[FRAC_W-1:0];
                REG_BASE:     base_reg     <= pwdata[WIDTH_W-1:0];
                REG_STEP:     step_reg     <= pwdata[WIDTH_W-1:0];
                REG_MAXWIN:   maxwin_reg   <= pwdata[MAXW_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FRACTION: prdata = 32'(fraction_reg);
            REG_BASE:     prdata = 32'(base_reg);
            REG_STEP:     prdata = 32'(step_reg);
            REG_MAXWIN:   prdata = 32'(maxwin_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.fraction    = fraction_reg;
    assign cfg.base_window = base_reg;
    assign cfg.window_step = step_reg;
    assign cfg.max_windows = maxwin_reg;

    swtq_front #(
        .MAX_RECORDS(MAX_RECORDS),
        .MAX_PARTICLES(MAX_PARTICLES)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .rec_in(rec_in),
        .rec_we(rec_we),
        .rec_waddr(rec_waddr),
        .rec_wframe(rec_wframe),
        .rec_wpid(rec_wpid),
        .push(push),
        .push_desc(push_desc),
        .push_count(push_count),
        .push_ready(q_not_full),
        .sweep_done(sweep_done)
    );

    // Raw record stores, written by the front, read by the sweep
    swtq_ram #(.WIDTH(FRAME_W), .DEPTH(MAX_RECORDS)) u_rec_frame (
        .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wframe),
        .raddr(rec_raddr), .rdata(rec_rframe)
    );
    swtq_ram #(.WIDTH(PID_W), .DEPTH(MAX_RECORDS)) u_rec_pid (
        .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wpid),
        .raddr(rec_raddr), .rdata(rec_rpid)
    );

    swtq_fifo #(.W(QW)) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_data({push_count, push_desc}),
        .not_full(q_not_full),
        .pop(q_pop),
        .pop_data(q_data),
        .not_empty(q_not_empty)
    );

    assign pop_desc  = q_data[$bits(run_desc_t)-1:0];
    assign pop_count = q_data[QW-1:$bits(run_desc_t)];

    swtq_back #(
        .MAX_RECORDS(MAX_RECORDS),
        .MAX_FRAMES(MAX_FRAMES),
        .MAX_PARTICLES(MAX_PARTICLES)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg),
        .run_avail(q_not_empty),
        .run_desc(pop_desc),
        .run_count(pop_count),
        .run_pop(q_pop),
        .rec_raddr(rec_raddr),
        .rec_rframe(rec_rframe),
        .rec_rpid(rec_rpid),
        .sweep_done(sweep_done),
        .res_out(res_out)
    );
endmodule

@@ sv/swtq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module swtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/swtq_fifo.sv @@
// Two-entry queue carrying run summaries from the front to the back.
`timescale 1ns / 1ps

module swtq_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         not_full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         not_empty
);
    logic [W-1:0] slot_reg [2];
    logic         wptr_reg;
    logic         rptr_reg;
    logic [1:0]   fill_reg;

    assign not_full  = (fill_reg != 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_data  = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && not_full)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (push && not_full)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop && not_empty)
            begin
                rptr_reg <= ~rptr_reg;
            end
            fill_reg <= fill_reg + 2'(push && not_full) - 2'(pop && not_empty);
        end
    end
endmodule

@@ sv/swtq_front.sv @@
// Front end: accepts records, stores them and tracks the run summary.
`timescale 1ns / 1ps

module swtq_front #(
    parameter int MAX_RECORDS   = 65536,
    parameter int MAX_PARTICLES = 1024
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    swtq_rec_if.sink                                rec_in,
    output logic                                    rec_we,
    output logic [$clog2(MAX_RECORDS)-1:0]          rec_waddr,
    output logic [swtq_pkg::FRAME_W-1:0]            rec_wframe,
    output logic [swtq_pkg::PID_W-1:0]              rec_wpid,
    output logic                                    push,
    output swtq_pkg::run_desc_t                     push_desc,
    output logic [$clog2(MAX_RECORDS+1)-1:0]        push_count,
    input  logic                                    push_ready,
    input  logic                                    sweep_done
);
    import swtq_pkg::*;

    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int AW = $clog2(MAX_RECORDS);

    logic [CW-1:0]      cnt_reg;
    logic [FRAME_W-1:0] early_reg;
    logic [FRAME_W-1:0] late_reg;
    logic [PID_W-1:0]   large_reg;
    logic               ovf_reg;
    logic               busy_reg;

    logic               accept;
    logic               cap_hit;
    logic               store;
    logic [CW-1:0]      cnt_next;
    run_desc_t          desc_next;

    assign rec_in.ready = !busy_reg && push_ready;
    assign accept       = rec_in.valid && rec_in.ready;
    assign cap_hit      = (cnt_reg >= CW'(MAX_RECORDS))
                       || (32'(rec_in.particle_id) >= MAX_PARTICLES);
    assign store        = accept && !cap_hit;

    assign rec_we     = store;
    assign rec_waddr  = cnt_reg[AW-1:0];
    assign rec_wframe = rec_in.frame_number;
    assign rec_wpid   = rec_in.particle_id;

    always_comb
    begin
        cnt_next                = cnt_reg + CW'(store);
        desc_next.over_capacity = ovf_reg || (accept && cap_hit);
        desc_next.earliest      = (store && rec_in.frame_number < early_reg)
                                ? rec_in.frame_number : early_reg;
        desc_next.latest        = (store && rec_in.frame_number > late_reg)
                                ? rec_in.frame_number : late_reg;
        desc_next.largest       = (store && rec_in.particle_id > large_reg)
                                ? rec_in.particle_id : large_reg;
    end

    assign push       = accept && rec_in.final_record;
    assign push_desc  = desc_next;
    assign push_count = cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            early_reg <= '1;
            late_reg  <= '0;
            large_reg <= '0;
            ovf_reg   <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else if (push)
        begin
            cnt_reg   <= '0;
            early_reg <= '1;
            late_reg  <= '0;
            large_reg <= '0;
            ovf_reg   <= 1'b0;
            busy_reg  <= 1'b1;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg   <= cnt_next;
                early_reg <= desc_next.earliest;
                late_reg  <= desc_next.latest;
                large_reg <= desc_next.largest;
                ovf_reg   <= desc_next.over_capacity;
            end
            if (sweep_done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end
endmodule

@@ sv/swtq_back.sv @@
// Back end: groups records by frame and sweeps window widths.
`timescale 1ns / 1ps

module swtq_back #(
    parameter int MAX_RECORDS   = 65536,
    parameter int MAX_FRAMES    = 4096,
    parameter int MAX_PARTICLES = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  swtq_pkg::cfg_t                   cfg,
    input  logic                             run_avail,
    input  swtq_pkg::run_desc_t              run_desc,
    input  logic [$clog2(MAX_RECORDS+1)-1:0] run_count,
    output logic                             run_pop,
    output logic [$clog2(MAX_RECORDS)-1:0]   rec_raddr,
    input  logic [swtq_pkg::FRAME_W-1:0]     rec_rframe,
    input  logic [swtq_pkg::PID_W-1:0]       rec_rpid,
    output logic                             sweep_done,
    swtq_res_if.source                       res_out
);
    import swtq_pkg::*;

    localparam int CW   = $clog2(MAX_RECORDS + 1);
    localparam int AW   = $clog2(MAX_RECORDS);
    localparam int OW   = $clog2(MAX_FRAMES + 1);
    localparam int PW   = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int PX   = (PW > PID_W) ? PW : PID_W;
    localparam int LW   = CW;
    localparam int GW   = $clog2(MAX_PARTICLES + 1);
    localparam int WW   = (OW > WIDTH_W) ? OW : WIDTH_W;
    localparam int TW   = WW + 1;
    localparam int LIMW = WW + 1;
    localparam int KW   = (LIMW > LW) ? LIMW : LW;
    localparam int MW   = FRAC_W + WW;
    localparam int BW   = CW + OW;
    localparam int SFW  = FRAME_W + 1;
    localparam int NS   = 35;

    typedef enum logic [NS-1:0] {
        S_IDLE      = 35'b1 << 0,
        S_CHK       = 35'b1 << 1,
        S_CLR       = 35'b1 << 2,
        S_CNT_RD    = 35'b1 << 3,
        S_CNT_FR    = 35'b1 << 4,
        S_CNT_WB    = 35'b1 << 5,
        S_PFX_RD    = 35'b1 << 6,
        S_PFX_WB    = 35'b1 << 7,
        S_PFX_END   = 35'b1 << 8,
        S_SCT_RD    = 35'b1 << 9,
        S_SCT_FR    = 35'b1 << 10,
        S_SCT_WB    = 35'b1 << 11,
        S_BRK       = 35'b1 << 12,
        S_BRK_CHK   = 35'b1 << 13,
        S_NW        = 35'b1 << 14,
        S_WIN       = 35'b1 << 15,
        S_PCLR      = 35'b1 << 16,
        S_FILL_OFF  = 35'b1 << 17,
        S_FILL_OFFW = 35'b1 << 18,
        S_FILL_RD   = 35'b1 << 19,
        S_FILL_Q    = 35'b1 << 20,
        S_FILL_WB   = 35'b1 << 21,
        S_GOOD_RD   = 35'b1 << 22,
        S_GOOD_CHK  = 35'b1 << 23,
        S_SLIDE     = 35'b1 << 24,
        S_RNG_A     = 35'b1 << 25,
        S_RNG_B     = 35'b1 << 26,
        S_RNG_C     = 35'b1 << 27,
        S_SL_RD     = 35'b1 << 28,
        S_SL_Q      = 35'b1 << 29,
        S_SL_WB     = 35'b1 << 30,
        S_BEST      = 35'b1 << 31,
        S_EMIT      = 35'b1 << 32,
        S_ERR       = 35'b1 << 33,
        S_DONE      = 35'b1 << 34
    } state_t;

    state_t             state_reg;
    state_t             state_next;

    logic [CW-1:0]      n_reg;
    logic [FRAME_W-1:0] e_reg;
    logic [FRAME_W-1:0] l_reg;
    logic [PID_W-1:0]   lg_reg;
    logic               ovf_reg;
    logic [OW-1:0]      span_reg;
    logic [OW-1:0]      f_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      end_reg;
    logic [CW-1:0]      run_reg;
    logic [CW-1:0]      maxper_reg;
    logic [OW-1:0]      off_reg;
    logic [PID_W-1:0]   pid_reg;
    logic [BW-1:0]      prod_reg;
    logic [WW-1:0]      rem_reg;
    logic [MAXW_W-1:0]  nw_reg;
    logic [MAXW_W-1:0]  k_reg;
    logic [WW-1:0]      w_reg;
    logic [LIMW-1:0]    limit_reg;
    logic [PW-1:0]      p_reg;
    logic [PW-1:0]      q_reg;
    logic [GW-1:0]      good_reg;
    logic [GW-1:0]      best_reg;
    logic [OW-1:0]      t_reg;
    logic [OW-1:0]      bt_reg;
    logic               enter_reg;
    logic [STATUS_W-1:0] err_reg;

    logic               out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [WIDTH_W-1:0] out_width_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [FRAME_W-1:0] out_start_reg;
    logic               out_last_reg;

    // memory ports
    logic               offs_we;
    logic [OW-1:0]      offs_waddr;
    logic [CW-1:0]      offs_wdata;
    logic [OW-1:0]      offs_raddr;
    logic [CW-1:0]      offs_rdata;
    logic               curs_we;
    logic [OW-1:0]      curs_waddr;
    logic [CW-1:0]      curs_wdata;
    logic [OW-1:0]      curs_raddr;
    logic [CW-1:0]      curs_rdata;
    logic               grp_we;
    logic [AW-1:0]      grp_waddr;
    logic [PID_W-1:0]   grp_wdata;
    logic [AW-1:0]      grp_raddr;
    logic [PID_W-1:0]   grp_rdata;
    logic               pres_we;
    logic [PW-1:0]      pres_waddr;
    logic [LW-1:0]      pres_wdata;
    logic [PW-1:0]      pres_raddr;
    logic [LW-1:0]      pres_rdata;

    logic [WIDTH_W-1:0] step_eff;
    logic [MAXW_W-1:0]  cap_eff;
    logic [SFW-1:0]     span_full;
    logic [OW-1:0]      rec_off;
    logic               slot_free;
    logic               p_last;
    logic               i_last;
    logic               len_at_limit;
    logic               len_inc_at_limit;
    logic               len_ge_limit;
    logic [GW-1:0]      good_inc;
    logic [OW-1:0]      a_addr;
    logic [OW-1:0]      b_addr;
    logic [TW-1:0]      t_plus_w;
    logic [CW+3:0]      ten_n;

    swtq_ram #(.WIDTH(CW), .DEPTH(MAX_FRAMES + 1)) u_offs (
        .clk(clk), .we(offs_we), .waddr(offs_waddr), .wdata(offs_wdata),
        .raddr(offs_raddr), .rdata(offs_rdata)
    );
    swtq_ram #(.WIDTH(CW), .DEPTH(MAX_FRAMES + 1)) u_curs (
        .clk(clk), .we(curs_we), .waddr(curs_waddr), .wdata(curs_wdata),
        .raddr(curs_raddr), .rdata(curs_rdata)
    );
    swtq_ram #(.WIDTH(PID_W), .DEPTH(MAX_RECORDS)) u_grp (
        .clk(clk), .we(grp_we), .waddr(grp_waddr), .wdata(grp_wdata),
        .raddr(grp_raddr), .rdata(grp_rdata)
    );
    swtq_ram #(.WIDTH(LW), .DEPTH(MAX_PARTICLES)) u_pres (
        .clk(clk), .we(pres_we), .waddr(pres_waddr), .wdata(pres_wdata),
        .raddr(pres_raddr), .rdata(pres_rdata)
    );

    assign step_eff  = (cfg.window_step == '0) ? WIDTH_W'(1) : cfg.window_step;
    assign cap_eff   = (cfg.max_windows == '0) ? MAXW_W'(1)
                     : ((cfg.max_windows > RESULT_CAP) ? RESULT_CAP : cfg.max_windows);
    assign span_full = {1'b0, l_reg} - {1'b0, e_reg} + SFW'(1);
    assign rec_off   = OW'(rec_rframe - e_reg);
    assign slot_free = !out_valid_reg || res_out.ready;
    assign p_last    = (PX'(p_reg) == PX'(lg_reg));
    assign i_last    = (i_reg + CW'(1) == end_reg);
    assign t_plus_w  = TW'(t_reg) + TW'(w_reg);
    assign ten_n     = ((CW+4)'(n_reg) << 3) + ((CW+4)'(n_reg) << 1);

    assign len_at_limit     = (KW'(pres_rdata) == KW'(limit_reg));
    assign len_inc_at_limit = (KW'(pres_rdata + LW'(1)) == KW'(limit_reg));
    assign len_ge_limit     = (KW'(pres_rdata) >= KW'(limit_reg));
    assign good_inc         = good_reg + GW'(len_ge_limit);

    // range bounds: leaving frame t-1, entering frame t+w
    assign a_addr = enter_reg ? OW'(t_plus_w) : (t_reg - OW'(1));
    assign b_addr = enter_reg ? OW'(t_plus_w + TW'(1)) : t_reg;

    assign run_pop    = (state_reg == S_IDLE) && run_avail;
    assign sweep_done = (state_reg == S_DONE);
    assign rec_raddr  = i_reg[AW-1:0];

    assign res_out.valid            = out_valid_reg;
    assign res_out.status           = out_status_reg;
    assign res_out.window_width     = out_width_reg;
    assign res_out.best_good_count  = out_count_reg;
    assign res_out.best_start_frame = out_start_reg;
    assign res_out.last_result      = out_last_reg;

    always_comb
    begin
        offs_we    = 1'b0;
        offs_waddr = f_reg;
        offs_wdata = '0;
        offs_raddr = f_reg;
        curs_we    = 1'b0;
        curs_waddr = f_reg;
        curs_wdata = run_reg;
        curs_raddr = rec_off;
        grp_we     = 1'b0;
        grp_waddr  = curs_rdata[AW-1:0];
        grp_wdata  = pid_reg;
        grp_raddr  = i_reg[AW-1:0];
        pres_we    = 1'b0;
        pres_waddr = q_reg;
        pres_wdata = '0;
        pres_raddr = PW'(grp_rdata);
        unique case (state_reg)
            S_CLR:
            begin
                offs_we = 1'b1;
            end
            S_CNT_FR:
            begin
                offs_raddr = rec_off;
            end
            S_CNT_WB:
            begin
                offs_we    = 1'b1;
                offs_waddr = off_reg;
                offs_wdata = offs_rdata + CW'(1);
            end
            S_PFX_WB:
            begin
                offs_we    = 1'b1;
                offs_wdata = run_reg;
                curs_we    = 1'b1;
            end
            S_PFX_END:
            begin
                offs_we    = 1'b1;
                offs_waddr = span_reg;
                offs_wdata = run_reg;
            end
            S_SCT_WB:
            begin
                grp_we     = 1'b1;
                curs_we    = 1'b1;
                curs_waddr = off_reg;
                curs_wdata = curs_rdata + CW'(1);
            end
            S_PCLR:
            begin
                pres_we    = 1'b1;
                pres_waddr = p_reg;
            end
            S_FILL_OFF:
            begin
                offs_raddr = OW'(w_reg + WW'(1));
            end
            S_FILL_WB:
            begin
                pres_we    = 1'b1;
                pres_wdata = pres_rdata + LW'(1);
            end
            S_GOOD_RD:
            begin
                pres_raddr = p_reg;
            end
            S_RNG_A:
            begin
                offs_raddr = a_addr;
            end
            S_RNG_B:
            begin
                offs_raddr = b_addr;
            end
            S_SL_WB:
            begin
                pres_we    = 1'b1;
                pres_wdata = enter_reg ? (pres_rdata + LW'(1)) : (pres_rdata - LW'(1));
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      state_next = run_avail ? S_CHK : S_IDLE;
            S_CHK:
            begin
                if (ovf_reg || span_full > SFW'(MAX_FRAMES))
                    state_next = S_ERR;
                else
                    state_next = S_CLR;
            end
            S_CLR:       state_next = (f_reg == span_reg - OW'(1)) ? S_CNT_RD : S_CLR;
            S_CNT_RD:    state_next = S_CNT_FR;
            S_CNT_FR:    state_next = S_CNT_WB;
            S_CNT_WB:    state_next = (i_reg + CW'(1) == n_reg) ? S_PFX_RD : S_CNT_RD;
            S_PFX_RD:    state_next = S_PFX_WB;
            S_PFX_WB:    state_next = (f_reg == span_reg - OW'(1)) ? S_PFX_END : S_PFX_RD;
            S_PFX_END:   state_next = S_SCT_RD;
            S_SCT_RD:    state_next = S_SCT_FR;
            S_SCT_FR:    state_next = S_SCT_WB;
            S_SCT_WB:    state_next = (i_reg + CW'(1) == n_reg) ? S_BRK : S_SCT_RD;
            S_BRK:       state_next = S_BRK_CHK;
            S_BRK_CHK:
            begin
                if (prod_reg > BW'(ten_n) || WW'(span_reg) <= WW'(cfg.base_window))
                    state_next = S_ERR;
                else
                    state_next = S_NW;
            end
            S_NW:
            begin
                if (rem_reg >= WW'(step_eff) && nw_reg < cap_eff)
                    state_next = S_NW;
                else if (nw_reg == '0)
                    state_next = S_ERR;
                else
                    state_next = S_WIN;
            end
            S_WIN:       state_next = S_PCLR;
            S_PCLR:      state_next = p_last ? S_FILL_OFF : S_PCLR;
            S_FILL_OFF:  state_next = S_FILL_OFFW;
            S_FILL_OFFW: state_next = (offs_rdata == '0) ? S_GOOD_RD : S_FILL_RD;
            S_FILL_RD:   state_next = S_FILL_Q;
            S_FILL_Q:    state_next = S_FILL_WB;
            S_FILL_WB:   state_next = i_last ? S_GOOD_RD : S_FILL_RD;
            S_GOOD_RD:   state_next = S_GOOD_CHK;
            S_GOOD_CHK:  state_next = p_last ? S_SLIDE : S_GOOD_RD;
            S_SLIDE:     state_next = (t_plus_w < TW'(span_reg)) ? S_RNG_A : S_EMIT;
            S_RNG_A:     state_next = S_RNG_B;
            S_RNG_B:     state_next = S_RNG_C;
            S_RNG_C:
            begin
                if (i_reg != offs_rdata)
                    state_next = S_SL_RD;
                else
                    state_next = enter_reg ? S_BEST : S_RNG_A;
            end
            S_SL_RD:     state_next = S_SL_Q;
            S_SL_Q:      state_next = S_SL_WB;
            S_SL_WB:
            begin
                if (!i_last)
                    state_next = S_SL_RD;
                else
                    state_next = enter_reg ? S_BEST : S_RNG_A;
            end
            S_BEST:      state_next = S_SLIDE;
            S_EMIT:
            begin
                if (slot_free)
                    state_next = (k_reg + MAXW_W'(1) == nw_reg) ? S_DONE : S_WIN;
            end
            S_ERR:       state_next = slot_free ? S_DONE : S_ERR;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_EMIT || state_reg == S_ERR) && slot_free)
                out_valid_reg <= 1'b1;
            else if (res_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                n_reg   <= run_count;
                e_reg   <= run_desc.earliest;
                l_reg   <= run_desc.latest;
                lg_reg  <= run_desc.largest;
                ovf_reg <= run_desc.over_capacity;
            end
            S_CHK:
            begin
                err_reg  <= ST_CAP;
                span_reg <= OW'(span_full);
                f_reg    <= '0;
            end
            S_CLR:
            begin
                f_reg <= f_reg + OW'(1);
                i_reg <= '0;
            end
            S_CNT_FR:
            begin
                off_reg <= rec_off;
            end
            S_CNT_WB:
            begin
                i_reg      <= i_reg + CW'(1);
                f_reg      <= '0;
                run_reg    <= '0;
                maxper_reg <= '0;
            end
            S_PFX_WB:
            begin
                run_reg <= run_reg + offs_rdata;
                if (offs_rdata > maxper_reg)
                    maxper_reg <= offs_rdata;
                f_reg <= f_reg + OW'(1);
                i_reg <= '0;
            end
            S_SCT_FR:
            begin
                off_reg <= rec_off;
                pid_reg <= rec_rpid;
            end
            S_SCT_WB:
            begin
                i_reg <= i_reg + CW'(1);
            end
            S_BRK:
            begin
                prod_reg <= BW'(maxper_reg) * BW'(span_reg);
            end
            S_BRK_CHK:
            begin
                err_reg <= (prod_reg > BW'(ten_n)) ? ST_BROKEN : ST_SHORT;
                rem_reg <= WW'(span_reg) - WW'(cfg.base_window);
                nw_reg  <= '0;
            end
            S_NW:
            begin
                if (rem_reg >= WW'(step_eff) && nw_reg < cap_eff)
                begin
                    rem_reg <= rem_reg - WW'(step_eff);
                    nw_reg  <= nw_reg + MAXW_W'(1);
                end
                k_reg <= '0;
                w_reg <= WW'(cfg.base_window);
            end
            S_WIN:
            begin
                limit_reg <= LIMW'((MW'(cfg.fraction) * MW'(w_reg)) >> 16);
                p_reg     <= '0;
            end
            S_PCLR:
            begin
                p_reg <= p_reg + PW'(1);
            end
            S_FILL_OFFW:
            begin
                end_reg  <= offs_rdata;
                i_reg    <= '0;
                p_reg    <= '0;
                good_reg <= '0;
            end
            S_FILL_Q:
            begin
                q_reg <= PW'(grp_rdata);
            end
            S_FILL_WB:
            begin
                i_reg    <= i_reg + CW'(1);
                p_reg    <= '0;
                good_reg <= '0;
            end
            S_GOOD_CHK:
            begin
                good_reg <= good_inc;
                p_reg    <= p_reg + PW'(1);
                best_reg <= good_inc;
                bt_reg   <= '0;
                t_reg    <= OW'(1);
            end
            S_SLIDE:
            begin
                enter_reg <= 1'b0;
            end
            S_RNG_B:
            begin
                i_reg <= offs_rdata;
            end
            S_RNG_C:
            begin
                end_reg <= offs_rdata;
                if (i_reg == offs_rdata)
                    enter_reg <= 1'b1;
            end
            S_SL_Q:
            begin
                q_reg <= PW'(grp_rdata);
            end
            S_SL_WB:
            begin
                if (enter_reg && len_inc_at_limit)
                    good_reg <= good_reg + GW'(1);
                else if (!enter_reg && len_at_limit)
                    good_reg <= good_reg - GW'(1);
                i_reg <= i_reg + CW'(1);
                if (i_last)
                    enter_reg <= 1'b1;
            end
            S_BEST:
            begin
                if (good_reg > best_reg)
                begin
                    best_reg <= good_reg;
                    bt_reg   <= t_reg;
                end
                t_reg <= t_reg + OW'(1);
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_status_reg <= ST_OK;
                    out_width_reg  <= w_reg[WIDTH_W-1:0];
                    out_count_reg  <= COUNT_W'(best_reg);
                    out_start_reg  <= e_reg + FRAME_W'(bt_reg);
                    out_last_reg   <= (k_reg + MAXW_W'(1) == nw_reg);
                    k_reg          <= k_reg + MAXW_W'(1);
                    w_reg          <= w_reg + WW'(step_eff);
                end
            end
            S_ERR:
            begin
                if (slot_free)
                begin
                    out_status_reg <= err_reg;
                    out_width_reg  <= '0;
                    out_count_reg  <= '0;
                    out_start_reg  <= '0;
                    out_last_reg   <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end
endmodule

@@ dv/sliding_window_track_quality_test.sv @@
// Testbench: checks the sliding window track quality block against its own predictor.
`timescale 1ns / 1ps

module sliding_window_track_quality_test;
    import swtq_pkg::*;

    // Generous cycle budget. Data sets with particle ids up to 1023 cost the most,
    // and only a handful of those are sent.
    localparam int unsigned CYCLE_LIMIT   = 6000000;
    localparam int unsigned RANDOM_ITEMS  = 470;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned REC_CAP       = 65536;
    localparam int unsigned FRAME_CAP     = 4096;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [WIDTH_W-1:0]  window_width;
        logic [COUNT_W-1:0]  best_good_count;
        logic [FRAME_W-1:0]  best_start_frame;
        logic                last_result;
    } sweep_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    swtq_rec_if rec_bus ();
    swtq_res_if res_bus ();

    sliding_window_track_quality u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rec_in  (rec_bus.sink),
        .res_out (res_bus.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Register mirror
    logic [FRAC_W-1:0]  cfg_fraction;
    logic [WIDTH_W-1:0] cfg_base;
    logic [WIDTH_W-1:0] cfg_step;
    logic [MAXW_W-1:0]  cfg_maxwin;

    // Mirror of the data set being loaded
    logic [FRAME_W-1:0] set_frames[$];
    logic [PID_W-1:0]   set_pids[$];
    logic [FRAME_W-1:0] set_earliest;
    logic [FRAME_W-1:0] set_latest;
    logic [PID_W-1:0]   set_largest;
    logic               set_over_cap;

    sweep_result_t pending_results[$];

    bit          steady_flow;
    int unsigned fail_count;
    int unsigned cycle_count = 0;
    int unsigned records_sent;
    int unsigned sets_sent;
    int unsigned results_checked;
    int unsigned settings_used;
    int unsigned wide_id_sets;

    // Clock and cycle guard
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: stall at random unless the flow is held steady
    always @(posedge clk)
    begin
        res_bus.ready <= steady_flow || ($urandom_range(99) >= 24);
    end

    // Compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin
        sweep_result_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: status %0d width %0d",
                       res_bus.status, res_bus.window_width);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (res_bus.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res_bus.status);
                    fail_count++;
                end
                if (res_bus.window_width !== want.window_width)
                begin
                    $error("window_width: expected %0d, got %0d",
                           want.window_width, res_bus.window_width);
                    fail_count++;
                end
                if (res_bus.best_good_count !== want.best_good_count)
                begin
                    $error("best_good_count: expected %0d, got %0d",
                           want.best_good_count, res_bus.best_good_count);
                    fail_count++;
                end
                if (res_bus.best_start_frame !== want.best_start_frame)
                begin
                    $error("best_start_frame: expected %0d, got %0d",
                           want.best_start_frame, res_bus.best_start_frame);
                    fail_count++;
                end
                if (res_bus.last_result !== want.last_result)
                begin
                    $error("last_result: expected %0d, got %0d",
                           want.last_result, res_bus.last_result);
                    fail_count++;
                end
            end
        end
    end

    function automatic void push_result(logic [STATUS_W-1:0] st, int unsigned w,
                                        int unsigned cnt, logic [FRAME_W-1:0] start,
                                        logic last);
        sweep_result_t r;
        r.status           = st;
        r.window_width     = w[WIDTH_W-1:0];
        r.best_good_count  = cnt[COUNT_W-1:0];
        r.best_start_frame = start;
        r.last_result      = last;
        pending_results.push_back(r);
    endfunction

    function automatic void clear_set();
        set_frames.delete();
        set_pids.delete();
        set_earliest = '1;
        set_latest   = '0;
        set_largest  = '0;
        set_over_cap = 1'b0;
    endfunction

    // Predict the whole sweep of the loaded data set
    function automatic void predict_sweep();
        int unsigned n, span, maxper, stp, wcap, nw, w, lim, good, best, best_t, q, off;
        int unsigned offs[FRAME_CAP+1];
        int unsigned plen[1024];
        int unsigned grouped[];
        longint unsigned prod;
        n = set_frames.size();
        maxper = 0;
        if (set_over_cap || set_latest < set_earliest)
        begin
            push_result(ST_CAP, 0, 0, '0, 1'b1);
            return;
        end
        span = int'(set_latest - set_earliest) + 1;
        if (span > FRAME_CAP)
        begin
            push_result(ST_CAP, 0, 0, '0, 1'b1);
            return;
        end
        // stable counting sort by frame offset
        foreach (offs[i])
            offs[i] = 0;
        for (int i = 0; i < n; i++)
            offs[int'(set_frames[i] - set_earliest) + 1]++;
        for (int f = 1; f <= span; f++)
        begin
            if (offs[f] > maxper)
                maxper = offs[f];
            offs[f] += offs[f-1];
        end
        grouped = new[n];
        for (int i = 0; i < n; i++)
        begin
            off = int'(set_frames[i] - set_earliest);
            grouped[offs[off]] = set_pids[i];
            offs[off]++;
        end
        for (int f = span; f >= 1; f--)
            offs[f] = offs[f-1];
        offs[0] = 0;

        prod = longint'(maxper) * span;
        if (prod > longint'(10) * n)
        begin
            push_result(ST_BROKEN, 0, 0, '0, 1'b1);
            return;
        end

        stp  = (cfg_step == 0) ? 1 : cfg_step;
        wcap = (cfg_maxwin == 0) ? 1 : ((cfg_maxwin > RESULT_CAP) ? RESULT_CAP : cfg_maxwin);
        nw   = (span > cfg_base) ? (span - cfg_base) / stp : 0;
        if (nw > wcap)
            nw = wcap;
        if (nw == 0)
        begin
            push_result(ST_SHORT, 0, 0, '0, 1'b1);
            return;
        end

        for (int k = 0; k < nw; k++)
        begin
            w    = cfg_base + k * stp;
            prod = (longint'(cfg_fraction) * w) >> 16;
            lim  = prod;
            good = 0;
            best_t = 0;
            foreach (plen[i])
                plen[i] = 0;
            for (int i = 0; i < offs[w+1]; i++)
                plen[grouped[i]]++;
            for (int p = 0; p <= set_largest; p++)
                if (plen[p] >= lim)
                    good++;
            best = good;
            // slide: drop the leaving frame, add the entering one
            for (int t = 1; t + w < span; t++)
            begin
                for (int i = offs[t-1]; i < offs[t]; i++)
                begin
                    q = grouped[i];
                    if (plen[q] == lim)
                        good--;
                    plen[q]--;
                end
                for (int i = offs[t+w]; i < offs[t+w+1]; i++)
                begin
                    q = grouped[i];
                    plen[q]++;
                    if (plen[q] == lim)
                        good++;
                end
                if (good > best)
                begin
                    best   = good;
                    best_t = t;
                end
            end
            push_result(ST_OK, w, best, set_earliest + best_t[FRAME_W-1:0],
                        (k + 1 == nw));
        end
    endfunction

    // Track one accepted request in the mirror
    function automatic void predict_record(logic [FRAME_W-1:0] fr, logic [PID_W-1:0] pid,
                                           logic fin);
        if (set_frames.size() >= REC_CAP)
            set_over_cap = 1'b1;
        else
        begin
            set_frames.push_back(fr);
            set_pids.push_back(pid);
            if (fr < set_earliest)
                set_earliest = fr;
            if (fr > set_latest)
                set_latest = fr;
            if (pid > set_largest)
                set_largest = pid;
        end
        records_sent++;
        if (fin)
        begin
            predict_sweep();
            clear_set();
            sets_sent++;
        end
    endfunction

    // Send one request; valid stays high afterwards so requests can run back to back
    task automatic send_record(logic [FRAME_W-1:0] fr, logic [PID_W-1:0] pid, logic fin);
        if (!steady_flow && $urandom_range(99) < 24)
        begin
            rec_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        rec_bus.valid        <= 1'b1;
        rec_bus.frame_number <= fr;
        rec_bus.particle_id  <= pid;
        rec_bus.final_record <= fin;
        do
            @(posedge clk);
        while (!rec_bus.ready);
        predict_record(fr, pid, fin);
    endtask

    // Hold the sender until every predicted result has come, then let the block settle
    task automatic drain_results();
        rec_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(logic [1:0] idx, logic wr, logic [31:0] data,
                              output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(logic [1:0] idx, logic [31:0] want);
        logic [31:0] got;
        apb_access(idx, 1'b0, '0, got);
        if (got !== want)
        begin
            $error("register %0d: expected %0d, got %0d", idx, want, got);
            fail_count++;
        end
    endtask

    // Write all four registers, mirror them and read them back
    task automatic set_config(int unsigned frac, int unsigned base, int unsigned stp,
                              int unsigned maxw);
        logic [31:0] unused;
        cfg_fraction = frac[FRAC_W-1:0];
        cfg_base     = base[WIDTH_W-1:0];
        cfg_step     = stp[WIDTH_W-1:0];
        cfg_maxwin   = maxw[MAXW_W-1:0];
        apb_access(REG_FRACTION, 1'b1, 32'(cfg_fraction), unused);
        apb_access(REG_BASE,     1'b1, 32'(cfg_base),     unused);
        apb_access(REG_STEP,     1'b1, 32'(cfg_step),     unused);
        apb_access(REG_MAXWIN,   1'b1, 32'(cfg_maxwin),   unused);
        check_register(REG_FRACTION, 32'(cfg_fraction));
        check_register(REG_BASE,     32'(cfg_base));
        check_register(REG_STEP,     32'(cfg_step));
        check_register(REG_MAXWIN,   32'(cfg_maxwin));
        settings_used++;
    endtask

    // Send one data set: every frame of the span at least once, extras at random,
    // shuffled, with the final mark on the last request
    task automatic send_dense_set(int unsigned span, int unsigned extra,
                                  logic [FRAME_W-1:0] first, int unsigned pid_top);
        int unsigned offsets[$];
        for (int i = 0; i < span; i++)
            offsets.push_back(i);
        for (int i = 0; i < extra; i++)
            offsets.push_back($urandom_range(span - 1));
        offsets.shuffle();
        foreach (offsets[i])
            send_record(first + offsets[i][FRAME_W-1:0], PID_W'($urandom_range(pid_top)),
                        i == offsets.size() - 1);
    endtask

    task automatic test_register_defaults();
        check_register(REG_FRACTION, 32'(FRACTION_RST));
        check_register(REG_BASE,     32'(BASE_RST));
        check_register(REG_STEP,     32'(STEP_RST));
        check_register(REG_MAXWIN,   32'(MAXWIN_RST));
    endtask

    // Span no wider than the reset base window
    task automatic test_short_span();
        send_record(20'd500, 10'd3, 1'b0);
        send_record(20'd502, 10'd1, 1'b0);
        send_record(20'd501, 10'd2, 1'b1);
        drain_results();
    endtask

    // Span beyond the frame store
    task automatic test_capacity_span();
        send_record(20'd100, 10'd0, 1'b0);
        send_record(20'd5200, 10'd5, 1'b1);
        drain_results();
    endtask

    // One crowded frame makes the broken-track ratio fail
    task automatic test_broken_tracks();
        for (int i = 0; i < 12; i++)
            send_record(20'd7, PID_W'(i), 1'b0);
        send_record(20'd27, 10'd2, 1'b1);
        drain_results();
    endtask

    // Top of the frame range, extreme ids, zero limit, zero step, oversized cap
    task automatic test_field_extremes();
        set_config(0, 4, 0, 127);
        send_record(20'hFFFFF, 10'd1023, 1'b0);
        send_record(20'hFFFFA, 10'd0, 1'b0);
        send_record(20'hFFFFB, 10'd1023, 1'b0);
        send_record(20'hFFFFC, 10'd512, 1'b0);
        send_record(20'hFFFFD, 10'd0, 1'b0);
        send_record(20'hFFFFE, 10'd1023, 1'b1);
        drain_results();
    endtask

    task automatic test_random_sets();
        int unsigned pick, span, base_now, fr0;
        int unsigned set_no;
        set_no = 0;
        while (records_sent < RANDOM_ITEMS - 30)
        begin
            // fresh settings every few sets; the drain also pauses the sender
            if (set_no % 6 == 0)
            begin
                drain_results();
                pick = $urandom_range(9);
                set_config(pick == 0 ? 0 : (pick == 1 ? 131071 : $urandom_range(131071)),
                           $urandom_range(1, 8), $urandom_range(0, 3),
                           pick == 2 ? 0 : (pick == 3 ? 127 : $urandom_range(1, 127)));
            end
            // hold the flow steady over one stretch of sets
            steady_flow = (set_no >= 8 && set_no < 14);
            base_now = (cfg_base == 0) ? 1 : cfg_base;
            pick = $urandom_range(99);
            if (pick < 83)
            begin
                span = base_now + $urandom_range(1, 30);
                fr0  = $urandom_range(0, 20'hFFFFF - span);
                if (pick >= 76 && wide_id_sets < 3)
                begin
                    wide_id_sets++;
                    send_dense_set(span, $urandom_range(0, span), FRAME_W'(fr0), 1023);
                end
                else
                    send_dense_set(span, $urandom_range(0, span), FRAME_W'(fr0),
                                   $urandom_range(1, 15));
            end
            else if (pick < 89)
            begin
                // crowded frame then one far record
                fr0 = $urandom_range(0, 20'hFFF00);
                for (int i = 0; i < 12; i++)
                    send_record(FRAME_W'(fr0), PID_W'($urandom_range(7)), 1'b0);
                send_record(FRAME_W'(fr0 + $urandom_range(11, 40)),
                            PID_W'($urandom_range(7)), 1'b1);
            end
            else if (pick < 94)
            begin
                // too short for even one width
                span = $urandom_range(1, base_now);
                fr0  = $urandom_range(0, 20'hFFFFF - span);
                send_dense_set(span, $urandom_range(0, 3), FRAME_W'(fr0), 7);
            end
            else
            begin
                fr0 = $urandom_range(0, 20'h7FFFF);
                send_record(FRAME_W'(fr0), PID_W'($urandom_range(1023)), 1'b0);
                send_record(FRAME_W'(fr0 + $urandom_range(FRAME_CAP, 20'h7FFFF)),
                            PID_W'($urandom_range(1023)), 1'b1);
            end
            set_no++;
        end
        steady_flow = 1'b0;
        drain_results();
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        rec_bus.valid        <= 1'b0;
        rec_bus.frame_number <= '0;
        rec_bus.particle_id  <= '0;
        rec_bus.final_record <= 1'b0;
        steady_flow     = 1'b0;
        fail_count      = 0;
        records_sent    = 0;
        sets_sent       = 0;
        results_checked = 0;
        settings_used   = 0;
        wide_id_sets    = 0;
        cfg_fraction    = FRACTION_RST;
        cfg_base        = BASE_RST;
        cfg_step        = STEP_RST;
        cfg_maxwin      = MAXWIN_RST;
        clear_set();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        test_short_span();
        set_config(32768, 4, 1, 3);
        test_capacity_span();
        test_broken_tracks();
        test_field_extremes();
        test_random_sets();

        $display("Sent %0d records in %0d data sets under %0d register settings;",
                 records_sent, sets_sent, settings_used);
        $display("checked %0d sweep results including all four status codes.",
                 results_checked);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
